@@ rtl/dscp_pkg.sv @@
// Shared constants and types of the dual sine correlation peak block.
package dscp_pkg;

   localparam int MAX_SAMPLES_DEF  = 1024;
   localparam int SINE_ENTRIES_DEF = 256;
   localparam int SAMPLE_BITS_DEF  = 12;

   localparam int PHASE_W = 16;
   localparam int STEP_W  = 15;
   localparam int SINE_W  = 16;
   localparam int PEAK_W  = 40;
   localparam int COUNT_W = 11;

   localparam logic [STEP_W-1:0] STEP_RESET = 15'd6554;

   // Flags that travel down the multiply-accumulate pipeline with each term.
   typedef struct packed {
      logic valid;
      logic first_term;
      logic last_term;
      logic first_lag;
      logic last_lag;
   } tag_type;

   // Sequencer status seen by the top level.
   typedef struct packed {
      logic filling;
      logic draining;
   } status_type;

endpackage

@@ rtl/dscp_ifs.sv @@
// Channel interfaces: sample pairs in, correlation peaks out, phase step register.
interface dscp_req_if #(parameter int SAMPLE_BITS = dscp_pkg::SAMPLE_BITS_DEF);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_a;
   logic [SAMPLE_BITS-1:0] sample_b;
   logic                   last_sample;

   modport source (output valid, sample_a, sample_b, last_sample, input ready);
   modport sink (input valid, sample_a, sample_b, last_sample, output ready);
endinterface

interface dscp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dscp_pkg::PEAK_W-1:0]  peak_a;
   logic signed [dscp_pkg::PEAK_W-1:0]  peak_b;
   logic [dscp_pkg::COUNT_W-1:0]        window_count;
   logic                                overflowed;

   modport source (output valid, peak_a, peak_b, window_count, overflowed, input ready);
   modport sink (input valid, peak_a, peak_b, window_count, overflowed, output ready);
endinterface

interface dscp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [dscp_pkg::STEP_W-1:0]   phase_step;

   modport source (output valid, phase_step, input ready);
   modport sink (input valid, phase_step, output ready);
endinterface

@@ rtl/dscp_store.sv @@
// Sample memory: one write port, one registered read port, both channels side by side.
module dscp_store #(
   parameter int DEPTH = dscp_pkg::MAX_SAMPLES_DEF,
   parameter int WIDTH = 2 * dscp_pkg::SAMPLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/dscp_sine_rom.sv @@
// Q15 sine table (Bhaskara approximation) with a registered read.
module dscp_sine_rom #(
   parameter int SINE_ENTRIES = dscp_pkg::SINE_ENTRIES_DEF
) (
   input  logic                                 clock,
   input  logic [$clog2(SINE_ENTRIES)-1:0]      idx,
   output logic signed [dscp_pkg::SINE_W-1:0]   sine
);
   import dscp_pkg::*;

   localparam int IDX_W = $clog2(SINE_ENTRIES);

   logic signed [SINE_W-1:0] rom [2**IDX_W];
   logic signed [SINE_W-1:0] sine_ff;

   for (genvar j = 0; j < 2**IDX_W; j++) begin : g_entry
      if (j < SINE_ENTRIES) begin : g_used
         localparam longint A   = (longint'(j) * 65536) / SINE_ENTRIES;
         localparam longint P   = A % 32768;
         localparam longint Q   = P * (32768 - P);
         localparam longint DEN = longint'(5) * longint'(1073741824) - 4 * Q;
         localparam longint MAG = (16 * Q * 32767) / DEN;
         localparam longint VAL = (A >= 32768) ? -MAG : MAG;
         assign rom[j] = SINE_W'(VAL);
      end else begin : g_unused
         assign rom[j] = '0;
      end
   end

   always_ff @(posedge clock) begin
      sine_ff <= rom[idx];
   end

   assign sine = sine_ff;
endmodule

@@ rtl/dscp_seq.sv @@
// Window loader, lag and term sequencer, phase accumulator and result register.
module dscp_seq #(
   parameter int MAX_SAMPLES  = dscp_pkg::MAX_SAMPLES_DEF,
   parameter int SINE_ENTRIES = dscp_pkg::SINE_ENTRIES_DEF,
   parameter int SAMPLE_BITS  = dscp_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   dscp_req_if.sink                              req,
   dscp_rsp_if.source                            rsp,
   dscp_csr_if.sink                              csr,
   output logic                                  mem_we,
   output logic [$clog2(MAX_SAMPLES)-1:0]        mem_waddr,
   output logic [2*SAMPLE_BITS-1:0]              mem_wdata,
   output logic                                  mem_re,
   output logic [$clog2(MAX_SAMPLES)-1:0]        mem_raddr,
   output dscp_pkg::tag_type                     tag_s1,
   output logic [$clog2(SINE_ENTRIES)-1:0]       sine_idx,
   input  logic                                  mac_done,
   input  logic signed [dscp_pkg::PEAK_W-1:0]    peak_a,
   input  logic signed [dscp_pkg::PEAK_W-1:0]    peak_b,
   output dscp_pkg::status_type                  status
);
   import dscp_pkg::*;

   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int IDX_W  = $clog2(SINE_ENTRIES);
   localparam int PROD_W = PHASE_W + IDX_W;

   localparam logic [1:0] S_FILL  = 2'd0;
   localparam logic [1:0] S_CALC  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic                ovf_ff, ovf_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic                win_ovf_ff, win_ovf_in;
   logic [CNT_W-1:0]    k_ff, k_in;
   logic [CNT_W-1:0]    i_ff, i_in;
   logic [PHASE_W-1:0]  lag_ph_ff, lag_ph_in;
   logic [PHASE_W-1:0]  cur_ph_ff, cur_ph_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                done_seen_ff, done_seen_in;
   tag_type             tag_ff, tag_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [PEAK_W-1:0]  rsp_peak_a_ff, rsp_peak_b_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_ovf_ff;
   logic                      rsp_load;

   logic                req_acc;
   logic                room;
   logic                issue;
   logic [CNT_W-1:0]    n_last;
   logic                i_end;
   logic                k_end;
   logic [PHASE_W-1:0]  step_ext;
   logic [PROD_W-1:0]   ph_prod;

   assign req.ready = (state_ff == S_FILL);
   assign req_acc   = req.valid & req.ready;
   assign room      = (fill_ff < CNT_W'(MAX_SAMPLES));

   assign mem_we    = req_acc & room;
   assign mem_waddr = fill_ff[ADDR_W-1:0];
   assign mem_wdata = {req.sample_a, req.sample_b};

   assign issue     = (state_ff == S_CALC);
   assign mem_re    = issue;
   assign mem_raddr = i_ff[ADDR_W-1:0];

   assign n_last   = CNT_W'(n_ff - 1'b1);
   assign i_end    = (i_ff == n_last);
   assign k_end    = (k_ff == n_last);
   assign step_ext = {1'b0, step_ff};

   // Table index is the top bits of phase times table length.
   assign ph_prod = {{IDX_W{1'b0}}, cur_ph_ff} * PROD_W'(SINE_ENTRIES);
   assign idx_in  = ph_prod[PHASE_W +: IDX_W];

   always_comb begin
      tag_in.valid      = issue;
      tag_in.first_term = (i_ff == '0);
      tag_in.last_term  = i_end;
      tag_in.first_lag  = (k_ff == '0);
      tag_in.last_lag   = i_end & k_end;
   end

   assign csr.ready = 1'b1;
   assign step_in   = csr.valid ? csr.phase_step : step_ff;

   assign rsp_load = (state_ff == S_DRAIN) & done_seen_ff & (~rsp_valid_ff | rsp.ready);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      win_ovf_in   = win_ovf_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      lag_ph_in    = lag_ph_ff;
      cur_ph_in    = cur_ph_ff;
      done_seen_in = done_seen_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;

      case (state_ff)
         S_FILL: begin
            if (req_acc) begin
               if (room) begin
                  fill_in = CNT_W'(fill_ff + 1'b1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req.last_sample) begin
                  n_in       = room ? CNT_W'(fill_ff + 1'b1) : fill_ff;
                  win_ovf_in = ovf_ff | ~room;
                  fill_in    = '0;
                  ovf_in     = 1'b0;
                  k_in       = '0;
                  i_in       = '0;
                  lag_ph_in  = '0;
                  cur_ph_in  = '0;
                  state_in   = S_CALC;
               end
            end
         end
         S_CALC: begin
            if (i_end) begin
               i_in      = '0;
               k_in      = CNT_W'(k_ff + 1'b1);
               lag_ph_in = lag_ph_ff + step_ext;
               cur_ph_in = lag_ph_ff + step_ext;
               if (k_end) begin
                  done_seen_in = 1'b0;
                  state_in     = S_DRAIN;
               end
            end else begin
               i_in      = CNT_W'(i_ff + 1'b1);
               cur_ph_in = cur_ph_ff + step_ext;
            end
         end
         S_DRAIN: begin
            if (mac_done) begin
               done_seen_in = 1'b1;
            end
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_FILL;
            end
         end
         default: begin
            state_in = S_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         step_ff      <= STEP_RESET;
         done_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tag_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         step_ff      <= step_in;
         done_seen_ff <= done_seen_in;
         rsp_valid_ff <= rsp_valid_in;
         tag_ff       <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      win_ovf_ff <= win_ovf_in;
      k_ff       <= k_in;
      i_ff       <= i_in;
      lag_ph_ff  <= lag_ph_in;
      cur_ph_ff  <= cur_ph_in;
      idx_ff     <= idx_in;
      if (rsp_load) begin
         rsp_peak_a_ff <= peak_a;
         rsp_peak_b_ff <= peak_b;
         rsp_count_ff  <= COUNT_W'(n_ff);
         rsp_ovf_ff    <= win_ovf_ff;
      end
   end

   assign tag_s1   = tag_ff;
   assign sine_idx = idx_ff;

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.peak_a       = rsp_peak_a_ff;
   assign rsp.peak_b       = rsp_peak_b_ff;
   assign rsp.window_count = rsp_count_ff;
   assign rsp.overflowed   = rsp_ovf_ff;

   always_comb begin
      status.filling  = (state_ff == S_FILL);
      status.draining = (state_ff == S_DRAIN);
   end
endmodule

@@ rtl/dscp_mac.sv @@
// Two-channel multiply-accumulate pipeline with running maximum and saturation.
module dscp_mac #(
   parameter int MAX_SAMPLES = dscp_pkg::MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = dscp_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dscp_pkg::tag_type                    tag_s1,
   input  logic [2*SAMPLE_BITS-1:0]             rdata,
   input  logic signed [dscp_pkg::SINE_W-1:0]   sine,
   output logic signed [dscp_pkg::PEAK_W-1:0]   peak_a,
   output logic signed [dscp_pkg::PEAK_W-1:0]   peak_b,
   output logic                                 done
);
   import dscp_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + 1 + SINE_W;
   localparam int RAW_W  = PROD_W + $clog2(MAX_SAMPLES) + 1;
   localparam int ACC_W  = (RAW_W > PEAK_W) ? RAW_W : PEAK_W + 1;

   tag_type tag_s2_ff, tag_s3_ff, tag_s4_ff;
   logic    done_ff;

   logic signed [SAMPLE_BITS:0]  smp_a_ff, smp_b_ff;
   logic signed [PROD_W-1:0]     prod_a_in, prod_b_in;
   logic signed [PROD_W-1:0]     prod_a_ff, prod_b_ff;
   logic signed [ACC_W-1:0]      ext_a, ext_b;
   logic signed [ACC_W-1:0]      acc_a_ff, acc_b_ff, acc_a_in, acc_b_in;
   logic signed [ACC_W-1:0]      best_a_ff, best_b_ff;

   assign prod_a_in = smp_a_ff * sine;
   assign prod_b_in = smp_b_ff * sine;

   assign ext_a = {{(ACC_W-PROD_W){prod_a_ff[PROD_W-1]}}, prod_a_ff};
   assign ext_b = {{(ACC_W-PROD_W){prod_b_ff[PROD_W-1]}}, prod_b_ff};

   assign acc_a_in = tag_s3_ff.first_term ? ext_a : acc_a_ff + ext_a;
   assign acc_b_in = tag_s3_ff.first_term ? ext_b : acc_b_ff + ext_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_s2_ff <= '0;
         tag_s3_ff <= '0;
         tag_s4_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         tag_s2_ff <= tag_s1;
         tag_s3_ff <= tag_s2_ff;
         tag_s4_ff <= tag_s3_ff;
         done_ff   <= tag_s4_ff.valid & tag_s4_ff.last_lag;
      end
   end

   always_ff @(posedge clock) begin
      smp_a_ff  <= {1'b0, rdata[2*SAMPLE_BITS-1:SAMPLE_BITS]};
      smp_b_ff  <= {1'b0, rdata[SAMPLE_BITS-1:0]};
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      if (tag_s3_ff.valid) begin
         acc_a_ff <= acc_a_in;
         acc_b_ff <= acc_b_in;
      end
      if (tag_s4_ff.valid && tag_s4_ff.last_term) begin
         if (tag_s4_ff.first_lag || acc_a_ff > best_a_ff) begin
            best_a_ff <= acc_a_ff;
         end
         if (tag_s4_ff.first_lag || acc_b_ff > best_b_ff) begin
            best_b_ff <= acc_b_ff;
         end
      end
   end

   // Clamp to the 40-bit signed range when the upper bits are not a sign run.
   always_comb begin
      if (&best_a_ff[ACC_W-1:PEAK_W-1] || ~|best_a_ff[ACC_W-1:PEAK_W-1]) begin
         peak_a = best_a_ff[PEAK_W-1:0];
      end else begin
         peak_a = best_a_ff[ACC_W-1] ? {1'b1, {(PEAK_W-1){1'b0}}} : {1'b0, {(PEAK_W-1){1'b1}}};
      end
      if (&best_b_ff[ACC_W-1:PEAK_W-1] || ~|best_b_ff[ACC_W-1:PEAK_W-1]) begin
         peak_b = best_b_ff[PEAK_W-1:0];
      end else begin
         peak_b = best_b_ff[ACC_W-1] ? {1'b1, {(PEAK_W-1){1'b0}}} : {1'b0, {(PEAK_W-1){1'b1}}};
      end
   end

   assign done = done_ff;
endmodule

@@ rtl/dual_sine_correlation_peak.sv @@
// Top level of the dual-channel sine-reference correlation peak detector.
//
// Sample pairs arrive as words on req_chan, one word per cycle while the block is
// loading; the word with last_sample set closes the window. Pairs beyond the
// capacity of the sample memory are dropped and reported through overflowed.
// Once a window closes, req_chan.ready stays low while both channels are
// correlated against the sine reference: one multiply-accumulate per channel per
// cycle, one memory read per cycle; a window of n pairs is read once for each of
// its n lags. The single read port of the sample memory sets that read rate.
// The result word (two peaks, pair count, overflow flag) waits in an output
// register on rsp_chan; loading of the next window starts at once, and only the
// hand-over of a following result waits if the receiver still stalls.
// csr_chan writes the phase step of the reference; it is always ready. The user
// must write it only while the block is idle; the block does not enforce this.
// Reset (synchronous, active high) empties the window and restores the default
// phase step; the sample memory is not cleared, as only entries written in the
// current window are ever read.
module dual_sine_correlation_peak #(
   parameter int MAX_SAMPLES  = dscp_pkg::MAX_SAMPLES_DEF,
   parameter int SINE_ENTRIES = dscp_pkg::SINE_ENTRIES_DEF,
   parameter int SAMPLE_BITS  = dscp_pkg::SAMPLE_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   dscp_req_if.sink      req_chan,
   dscp_rsp_if.source    rsp_chan,
   dscp_csr_if.sink      csr_chan
);
   import dscp_pkg::*;

   localparam int ADDR_W = $clog2(MAX_SAMPLES);
   localparam int IDX_W  = $clog2(SINE_ENTRIES);

   // Memory access from the sequencer: writes while loading, reads while correlating.
   logic                     mem_we;
   logic [ADDR_W-1:0]        mem_waddr;
   logic [2*SAMPLE_BITS-1:0] mem_wdata;
   logic                     mem_re;
   logic [ADDR_W-1:0]        mem_raddr;
   logic [2*SAMPLE_BITS-1:0] mem_rdata;

   // Pipeline tag and table index leave the sequencer in the cycle after issue,
   // lined up with the memory read data.
   tag_type                  tag_s1;
   logic [IDX_W-1:0]         sine_idx;
   logic signed [SINE_W-1:0] sine;

   logic                     mac_done;
   logic signed [PEAK_W-1:0] peak_a;
   logic signed [PEAK_W-1:0] peak_b;
   status_type               seq_status;

   dscp_seq #(
      .MAX_SAMPLES  (MAX_SAMPLES),
      .SINE_ENTRIES (SINE_ENTRIES),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr       (csr_chan),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .tag_s1    (tag_s1),
      .sine_idx  (sine_idx),
      .mac_done  (mac_done),
      .peak_a    (peak_a),
      .peak_b    (peak_b),
      .status    (seq_status)
   );

   // Both channels share one memory word so that a single read feeds both MACs.
   dscp_store #(
      .DEPTH (MAX_SAMPLES),
      .WIDTH (2 * SAMPLE_BITS)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   dscp_sine_rom #(
      .SINE_ENTRIES (SINE_ENTRIES)
   ) u_sine (
      .clock (clock),
      .idx   (sine_idx),
      .sine  (sine)
   );

   dscp_mac #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .tag_s1 (tag_s1),
      .rdata  (mem_rdata),
      .sine   (sine),
      .peak_a (peak_a),
      .peak_b (peak_b),
      .done   (mac_done)
   );

`ifndef ASSERT_OFF
   // The sample memory is never written and read in the same cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !mem_re)
      else $error("sample memory written while being read");

   // The end of the correlation only ever arrives while the sequencer waits for it.
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> seq_status.draining)
      else $error("correlation finished outside the drain phase");

   // A closing word stops further loading until the window has been correlated.
   a_close_stops_load: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last_sample) |=> !req_chan.ready)
      else $error("input still ready after the window closed");

   // Reads are only issued once loading has stopped.
   a_read_not_filling: assert property (@(posedge clock) disable iff (reset)
      mem_re |-> !seq_status.filling)
      else $error("sample memory read while loading");
`endif
endmodule

@@ sim/dual_sine_correlation_peak_tb.sv @@
// Self-checking testbench of the dual sine correlation peak block: windows in, peaks checked.
module dual_sine_correlation_peak_tb;
   import dscp_pkg::*;

   // Sizes of the block as built with its default parameters.
   localparam int SMP_W     = SAMPLE_BITS_DEF;
   localparam int MAX_PAIRS = MAX_SAMPLES_DEF;
   localparam int SINE_N    = SINE_ENTRIES_DEF;

   localparam logic [SMP_W-1:0]  SMP_MAX  = '1;
   localparam logic [STEP_W-1:0] STEP_MIN = 15'd1;
   localparam logic [STEP_W-1:0] STEP_MAX = 15'h7FFF;
   localparam logic [STEP_W-1:0] STEP_OFF = 15'd0;

   localparam longint PEAK_HI = 64'sd549755813887;
   localparam longint PEAK_LO = -64'sd549755813888;

   // Waits that let the block empty its pipeline after a window, before any register write
   // and at the very end.
   localparam int DRAIN_CYCLES = 12;
   localparam int TAIL_CYCLES  = 32;
   // The longest quiet stretch of a correct run is the correlation of a 48-pair window
   // waiting behind a receiver hold of HOLD_CYCLES; the watchdog allows several
   // times that.
   localparam int QUIET_LIMIT  = 20_000;
   localparam int HOLD_CYCLES  = 1500;
   localparam int RANDOM_WORDS = 520;
   localparam int PHASES       = 6;

   typedef enum logic [2:0] {
      FILL_ZERO,
      FILL_FULL,
      FILL_SPLIT,
      FILL_TOGGLE,
      FILL_RANDOM
   } fill_mode_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   typedef struct packed {
      logic signed [PEAK_W-1:0] peak_a;
      logic signed [PEAK_W-1:0] peak_b;
      logic [COUNT_W-1:0]       count;
      logic                     ovf;
   } window_result_type;

   // One directed window: an optional phase step written beforehand, the number of pairs,
   // how they are filled and, where it is obvious, the result typed in by hand.
   typedef struct packed {
      logic                set_step;
      logic [STEP_W-1:0]   step;
      logic [11:0]         pairs;
      fill_mode_type       mode;
      logic                typed;
      window_result_type   known;
   } window_row_type;

   // A single pair always correlates with sine entry 0, which is zero. A zero phase step
   // keeps the whole reference at zero.
   localparam window_row_type DIRECTED [7] = '{
      '{1'b0, STEP_OFF,   12'd1,    FILL_FULL,   1'b1, '{40'sd0, 40'sd0, 11'd1, 1'b0}},
      '{1'b0, STEP_OFF,   12'd2,    FILL_FULL,   1'b0, '0},
      '{1'b0, STEP_OFF,   12'd6,    FILL_SPLIT,  1'b0, '0},
      '{1'b1, STEP_MIN,   12'd12,   FILL_TOGGLE, 1'b0, '0},
      '{1'b1, STEP_MAX,   12'd12,   FILL_FULL,   1'b0, '0},
      '{1'b1, 15'd16384,  12'd4,    FILL_TOGGLE, 1'b0, '0},
      '{1'b1, STEP_OFF,   12'd5,    FILL_FULL,   1'b1, '{40'sd0, 40'sd0, 11'd5, 1'b0}}
   };

   logic clock;
   logic reset;

   dscp_req_if req_if ();
   dscp_rsp_if rsp_if ();
   dscp_csr_if csr_if ();

   dual_sine_correlation_peak dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #5 clock = ~clock;

   // Predictor state: the phase step in force, the pairs of the open window and the
   // reference wave rebuilt for each closing window.
   int                sine_lut  [SINE_N];
   int                ref_wave  [2*MAX_PAIRS];
   logic [SMP_W-1:0]  win_a     [MAX_PAIRS];
   logic [SMP_W-1:0]  win_b     [MAX_PAIRS];
   logic [STEP_W-1:0] step_now;
   int                fill_now;
   logic              dropped_now;

   window_result_type window_results [$];
   logic              known_pending;
   window_result_type known_result;

   int                fail_count;
   int                shown;
   int                burst_left;
   logic              hold_req;

   // Builds the Q15 sine table from Bhaskara's approximation, in exact integers.
   function automatic void build_sine_lut();
      longint a, p, q, den;
      for (int j = 0; j < SINE_N; j++) begin
         a   = (longint'(j) * 65536) / SINE_N;
         p   = a % 32768;
         q   = p * (32768 - p);
         den = 64'sd5368709120 - 4 * q;
         sine_lut[j] = int'((16 * q * 32767) / den);
         if (a >= 32768) sine_lut[j] = -sine_lut[j];
      end
   endfunction

   // Largest sum over all lags of one channel against the reference wave, saturated to
   // the 40-bit range of the result.
   function automatic logic signed [PEAK_W-1:0] channel_peak(input logic use_b, input int n);
      longint best;
      longint acc;
      best = 0;
      for (int k = 0; k < n; k++) begin
         acc = 0;
         for (int i = 0; i < n; i++)
            acc += longint'(use_b ? win_b[i] : win_a[i]) * longint'(ref_wave[k+i]);
         if (k == 0 || acc > best) best = acc;
      end
      if (best > PEAK_HI) best = PEAK_HI;
      if (best < PEAK_LO) best = PEAK_LO;
      return best[PEAK_W-1:0];
   endfunction

   // Takes in one accepted word. A closing word yields the expected result of the window,
   // either the one typed in the table or the one worked out here.
   function automatic void absorb_pair(input logic [SMP_W-1:0] a, input logic [SMP_W-1:0] b,
                                       input logic last);
      window_result_type r;
      longint            ph;
      if (fill_now < MAX_PAIRS) begin
         win_a[fill_now] = a;
         win_b[fill_now] = b;
         fill_now++;
      end else begin
         dropped_now = 1'b1;
      end
      if (last) begin
         if (known_pending) begin
            r = known_result;
            known_pending = 1'b0;
         end else begin
            for (int m = 0; m + 1 < 2 * fill_now; m++) begin
               ph = (longint'(m) * step_now) & 64'hFFFF;
               ref_wave[m] = sine_lut[(ph * SINE_N) >> 16];
            end
            r.peak_a = channel_peak(1'b0, fill_now);
            r.peak_b = channel_peak(1'b1, fill_now);
            r.count  = fill_now[COUNT_W-1:0];
            r.ovf    = dropped_now;
         end
         window_results.insert(window_results.size(), r);
         fill_now    = 0;
         dropped_now = 1'b0;
      end
   endfunction

   // Mostly readings across the full range, with the rails and small values mixed in.
   function automatic logic [SMP_W-1:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return SMP_MAX;
         2: return SMP_W'($urandom_range(0, 15));
         default: return SMP_W'($urandom_range(0, 4095));
      endcase
   endfunction

   // Offers one word and waits for its handshake. The sender works in bursts; at the start
   // of each burst valid drops for a random gap, and now and then a long burst runs with
   // no gap at all.
   task automatic send_pair(input logic [SMP_W-1:0] a, input logic [SMP_W-1:0] b,
                            input logic last);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
         gap        = $urandom_range(1, 5);
      end
      burst_left--;
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid       <= 1'b1;
      req_if.sample_a    <= a;
      req_if.sample_b    <= b;
      req_if.last_sample <= last;
      do @(posedge clock); while (!req_if.ready);
      absorb_pair(a, b, last);
   endtask

   // Lowers valid at the first falling edge after the last accepted word.
   task automatic idle_req();
      @(negedge clock);
      req_if.valid <= 1'b0;
   endtask

   // The phase step is only written once every result is home and the pipeline has had
   // time to empty.
   task automatic set_phase_step(input logic [STEP_W-1:0] value);
      idle_req();
      while (window_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_if.valid      <= 1'b1;
      csr_if.phase_step <= value;
      do @(posedge clock); while (!csr_if.ready);
      step_now = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic report_failure(input string what, input window_result_type want);
      fail_count++;
      if (shown < 10) begin
         shown++;
         $display("%s: expected peak_a=%0d peak_b=%0d count=%0d overflowed=%0b",
                  what, want.peak_a, want.peak_b, want.count, want.ovf);
         $display("   got peak_a=%0d peak_b=%0d count=%0d overflowed=%0b",
                  rsp_if.peak_a, rsp_if.peak_b, rsp_if.window_count, rsp_if.overflowed);
      end
   endtask

   // Every result word is checked against the oldest expectation, one field at a time.
   // A word that arrives with nothing expected is a failure in its own right.
   always @(posedge clock) begin
      window_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (window_results.size() == 0) begin
            report_failure("unexpected result word", '0);
         end else begin
            want = window_results.pop_front();
            if (rsp_if.peak_a !== want.peak_a || rsp_if.peak_b !== want.peak_b ||
                rsp_if.window_count !== want.count || rsp_if.overflowed !== want.ovf)
               report_failure("result mismatch", want);
         end
      end
   end

   // The watchdog counts cycles in which no word moves on any channel.
   int quiet_cycles;
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", quiet_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   // The receiver changes its stall pattern after each randomly chosen span. When asked, it holds
   // ready low for a long stretch so that the output register stays full, the following
   // window finishes behind it and the block has to stall its input.
   initial begin
      stall_mode_type mode;
      int             span;
      int             tick;
      tick = 0;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            mode = stall_mode_type'($urandom_range(0, 3));
            span = $urandom_range(50, 300);
            repeat (span) begin
               case (mode)
                  STALL_NONE:     rsp_if.ready <= 1'b1;
                  STALL_RANDOM:   rsp_if.ready <= ($urandom_range(0, 3) != 0);
                  STALL_PERIODIC: rsp_if.ready <= (tick % 8 >= 3);
                  STALL_HEAVY:    rsp_if.ready <= ($urandom_range(0, 3) == 0);
                  default:        rsp_if.ready <= 1'b1;
               endcase
               tick++;
               @(negedge clock);
            end
         end
      end
   end

   initial begin
      window_row_type    row;
      logic [SMP_W-1:0]  a;
      logic [SMP_W-1:0]  b;
      logic [STEP_W-1:0] phase_plan [PHASES];
      int                len;
      int                sent;
      int                pick;

      // Every input is known from the first instant.
      clock              = 1'b0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.sample_a    = '0;
      req_if.sample_b    = '0;
      req_if.last_sample = 1'b0;
      csr_if.valid       = 1'b0;
      csr_if.phase_step  = '0;

      step_now      = STEP_RESET;
      fill_now      = 0;
      dropped_now   = 1'b0;
      known_pending = 1'b0;
      known_result  = '0;
      fail_count    = 0;
      shown         = 0;
      burst_left    = 0;
      hold_req      = 1'b0;
      build_sine_lut();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed windows: the first ones run on the phase step left by reset, the rest
      // cover the slowest and fastest steps, a quarter cycle and a zero step.
      for (int r = 0; r < $size(DIRECTED); r++) begin
         row = DIRECTED[r];
         if (row.set_step) set_phase_step(row.step);
         known_pending = row.typed;
         known_result  = row.known;
         for (int i = 0; i < row.pairs; i++) begin
            case (row.mode)
               FILL_ZERO:   begin a = '0;      b = '0;      end
               FILL_FULL:   begin a = SMP_MAX; b = SMP_MAX; end
               FILL_SPLIT:  begin a = SMP_MAX; b = '0;      end
               FILL_TOGGLE: begin a = i[0] ? SMP_MAX : '0; b = ~a; end
               default:     begin a = rand_sample(); b = rand_sample(); end
            endcase
            send_pair(a, b, i == row.pairs - 1);
         end
      end

      // Random windows in several phases, each with its own phase step. Most windows are
      // short, since the correlation reads the whole window once for each lag.
      phase_plan = '{STEP_MAX, STEP_MIN, STEP_RESET, 15'd8192,
                     STEP_W'($urandom_range(1, 32767)), STEP_W'($urandom_range(1, 32767))};
      for (int p = 0; p < PHASES; p++) begin
         set_phase_step(phase_plan[p]);
         if (p == 1) hold_req = 1'b1;
         sent = 0;
         while (sent < RANDOM_WORDS / PHASES) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)      len = $urandom_range(1, 8);
            else if (pick < 9) len = $urandom_range(9, 24);
            else               len = $urandom_range(25, 48);
            for (int i = 0; i < len; i++)
               send_pair(rand_sample(), rand_sample(), i == len - 1);
            sent += len;
         end
      end

      idle_req();
      while (window_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ dual_sine_correlation_peak.f @@
rtl/dscp_pkg.sv
rtl/dscp_ifs.sv
rtl/dscp_store.sv
rtl/dscp_sine_rom.sv
rtl/dscp_seq.sv
rtl/dscp_mac.sv
rtl/dual_sine_correlation_peak.sv
sim/dual_sine_correlation_peak_tb.sv
